>>> rtl/core/tequ_pkg.sv
// Timed event queue: shared widths, codes and payload types.
// Used by every file of the block; depends on nothing.
package tequ_pkg;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned HANDLE_BITS = 16;
	localparam int unsigned TIME_BITS   = 32;

	typedef enum logic {
		OP_SCHEDULE = 1'b0,
		OP_CHECK    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_FIRED    = 2'd0,
		KIND_ACCEPTED = 2'd1,
		KIND_REJECTED = 2'd2
	} result_kind_t;

	typedef struct packed {
		op_t                    operation;
		logic [TIME_BITS-1:0]   now_ms;
		logic [TIME_BITS-1:0]   delay_ms;
		logic [HANDLE_BITS-1:0] event_handle;
	} req_t;

	typedef struct packed {
		result_kind_t           result_kind;
		logic [HANDLE_BITS-1:0] fired_handle;
		logic [TIME_BITS-1:0]   due_time;
		logic                   last_of_run;
	} rsp_t;

	// one queue entry as held in the memory
	typedef struct packed {
		logic [TIME_BITS-1:0]   deadline;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} slot_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} slot_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/core/timed_event_queue_unit.sv
// Timed event queue top level: request sequencer, deadline scan and result
// register. Uses tequ_pkg, tequ_mem and tequ_slots.
//
//  port group  dir  payload           transfer when
//  req_*       in   tequ_pkg::req_t   req_valid & req_ready
//  rsp_*       out  tequ_pkg::rsp_t   rsp_valid & rsp_ready
//
// Schedule: accept, then load of the result register.
// Check: each fired event needs a full scan of the entry memory through its
// single read port; a closing scan finds nothing more due. Empty queue: no scan.
// Reset clears all occupancy marks at once; no sweep needed.
// A full result register stalls the sequencer in its emit step only; a new
// request is taken while the previous result still waits.
module timed_event_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = tequ_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tequ_pkg::req_t req_item,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tequ_pkg::rsp_t rsp_item
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned TW    = tequ_pkg::TIME_BITS;
	localparam int unsigned HW    = tequ_pkg::HANDLE_BITS;

	tequ_pkg::state_t state_q, state_d, emit_next_q;

	logic [TW-1:0]    now_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] best_rank_q;
	logic [TW-1:0]    best_dl_q;
	logic [HW-1:0]    best_hd_q;

	logic             held_q;
	logic [HW-1:0]    held_hd_q;
	logic [TW-1:0]    held_dl_q;

	tequ_pkg::rsp_t   emit_q;
	tequ_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic                 accept, slot_free, is_due, start_scan;
	logic [TW-1:0]        sched_due;
	logic                 wr_en;
	tequ_pkg::entry_t     wr_data, rd_data;
	tequ_pkg::slot_cmd_t  slot_cmd;
	tequ_pkg::slot_stat_t slot_stat;
	logic [IDX_W-1:0]     free_idx, look_rank;
	logic                 look_valid, better;

	tequ_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (free_idx),
		.wr_data (wr_data),
		.rd_en   (state_q == tequ_pkg::ST_SCAN),
		.rd_idx  (scan_idx_q),
		.rd_data (rd_data)
	);

	tequ_slots #(.DEPTH(QUEUE_DEPTH)) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (slot_cmd),
		.rem_idx    (best_idx_q),
		.rem_rank   (best_rank_q),
		.look_idx   (rd_idx_s1),
		.stat       (slot_stat),
		.free_idx   (free_idx),
		.look_valid (look_valid),
		.look_rank  (look_rank)
	);

	assign req_ready = (state_q == tequ_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign sched_due = req_item.now_ms + req_item.delay_ms;
	assign is_due    = best_found_q && (best_dl_q <= now_q);

	assign wr_en            = accept && req_item.operation == tequ_pkg::OP_SCHEDULE
	                          && !slot_stat.full;
	assign wr_data.deadline = sched_due;
	assign wr_data.handle   = req_item.event_handle;
	assign slot_cmd.ins     = wr_en;
	assign slot_cmd.rem     = (state_q == tequ_pkg::ST_DECIDE) && is_due;

	assign start_scan =
		(accept && req_item.operation == tequ_pkg::OP_CHECK && !slot_stat.empty)
		|| (state_q == tequ_pkg::ST_DECIDE && !held_q && is_due)
		|| (state_q == tequ_pkg::ST_EMIT && slot_free && emit_next_q == tequ_pkg::ST_SCAN);

	// earliest deadline wins, then lowest age rank
	assign better = rd_vld_s1 && look_valid &&
		(!best_found_q || rd_data.deadline < best_dl_q ||
		 (rd_data.deadline == best_dl_q && look_rank < best_rank_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tequ_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_item.operation == tequ_pkg::OP_SCHEDULE) begin
						state_d = tequ_pkg::ST_EMIT;
					end else if (!slot_stat.empty) begin
						state_d = tequ_pkg::ST_SCAN;
					end
				end
			end
			tequ_pkg::ST_SCAN: begin
				if (scan_idx_q == IDX_W'(QUEUE_DEPTH - 1)) begin
					state_d = tequ_pkg::ST_DRAIN;
				end
			end
			tequ_pkg::ST_DRAIN: begin
				state_d = tequ_pkg::ST_DECIDE;
			end
			tequ_pkg::ST_DECIDE: begin
				if (held_q) begin
					state_d = tequ_pkg::ST_EMIT;
				end else if (is_due) begin
					state_d = tequ_pkg::ST_SCAN;
				end else begin
					state_d = tequ_pkg::ST_IDLE;
				end
			end
			tequ_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = emit_next_q;
				end
			end
			default: state_d = tequ_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tequ_pkg::ST_IDLE;
			emit_next_q  <= tequ_pkg::ST_IDLE;
			rd_vld_s1    <= 1'b0;
			best_found_q <= 1'b0;
			held_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == tequ_pkg::ST_SCAN);
			if (start_scan) begin
				best_found_q <= 1'b0;
			end else if (better) begin
				best_found_q <= 1'b1;
			end
			if (state_q == tequ_pkg::ST_DECIDE) begin
				held_q <= is_due;
			end
			if (accept && req_item.operation == tequ_pkg::OP_SCHEDULE) begin
				emit_next_q <= tequ_pkg::ST_IDLE;
			end else if (state_q == tequ_pkg::ST_DECIDE && held_q) begin
				emit_next_q <= is_due ? tequ_pkg::ST_SCAN : tequ_pkg::ST_IDLE;
			end
			if (state_q == tequ_pkg::ST_EMIT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (start_scan) begin
			scan_idx_q <= '0;
		end else if (state_q == tequ_pkg::ST_SCAN) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (accept) begin
			now_q <= req_item.now_ms;
		end
		if (better) begin
			best_idx_q  <= rd_idx_s1;
			best_rank_q <= look_rank;
			best_dl_q   <= rd_data.deadline;
			best_hd_q   <= rd_data.handle;
		end
		// a fired event is held until the next scan tells whether it ends the run
		if (state_q == tequ_pkg::ST_DECIDE && is_due) begin
			held_hd_q <= best_hd_q;
			held_dl_q <= best_dl_q;
		end
		if (accept && req_item.operation == tequ_pkg::OP_SCHEDULE) begin
			emit_q.result_kind  <= slot_stat.full ? tequ_pkg::KIND_REJECTED
			                                      : tequ_pkg::KIND_ACCEPTED;
			emit_q.fired_handle <= req_item.event_handle;
			emit_q.due_time     <= sched_due;
			emit_q.last_of_run  <= 1'b1;
		end else if (state_q == tequ_pkg::ST_DECIDE && held_q) begin
			emit_q.result_kind  <= tequ_pkg::KIND_FIRED;
			emit_q.fired_handle <= held_hd_q;
			emit_q.due_time     <= held_dl_q;
			emit_q.last_of_run  <= !is_due;
		end
		if (state_q == tequ_pkg::ST_EMIT && slot_free) begin
			rsp_q <= emit_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

>>> rtl/core/tequ_mem.sv
// Entry memory of the timed event queue: deadline and handle per slot.
// One write port, one read port with registered data. Uses tequ_pkg.
module tequ_mem #(
	parameter int unsigned DEPTH = tequ_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  tequ_pkg::entry_t         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	output tequ_pkg::entry_t         rd_data
);

	tequ_pkg::entry_t mem_q [DEPTH];
	tequ_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/tequ_slots.sv
// Slot bookkeeping of the timed event queue: occupancy marks, dense age
// ranks, fill count and free-slot search. Uses tequ_pkg.
module tequ_slots #(
	parameter int unsigned DEPTH = tequ_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tequ_pkg::slot_cmd_t      cmd,
	input  logic [$clog2(DEPTH)-1:0] rem_idx,
	input  logic [$clog2(DEPTH)-1:0] rem_rank,
	input  logic [$clog2(DEPTH)-1:0] look_idx,
	output tequ_pkg::slot_stat_t     stat,
	output logic [$clog2(DEPTH)-1:0] free_idx,
	output logic                     look_valid,
	output logic [$clog2(DEPTH)-1:0] look_rank
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0] valid_q;
	logic [IDX_W-1:0] rank_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign look_valid = valid_q[look_idx];
	assign look_rank  = rank_q[look_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.ins) begin
			valid_q[free_idx] <= 1'b1;
			count_q           <= count_q + 1'b1;
		end else if (cmd.rem) begin
			valid_q[rem_idx] <= 1'b0;
			count_q          <= count_q - 1'b1;
		end
	end

	// new entry is youngest; on removal every younger entry moves down one
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.ins && free_idx == IDX_W'(i)) begin
				rank_q[i] <= count_q[IDX_W-1:0];
			end else if (cmd.rem && valid_q[i] && rank_q[i] > rem_rank) begin
				rank_q[i] <= rank_q[i] - 1'b1;
			end
		end
	end

endmodule

>>> tb/sv/timed_event_queue_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for timed_event_queue_unit: directed and random timer traffic, each result
// checked in order against an in-bench model of the deadline queue.
// Depends on tequ_pkg and the block's RTL; reads nothing else.
module timed_event_queue_unit_tb;

	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned DRAIN_CYCLES   = 400;  // above a full sixteen-event check
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned TW             = tequ_pkg::TIME_BITS;
	localparam int unsigned HW             = tequ_pkg::HANDLE_BITS;
	localparam int unsigned QD             = tequ_pkg::QUEUE_DEPTH;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	tequ_pkg::req_t req_item;
	logic rsp_valid;
	logic rsp_ready;
	tequ_pkg::rsp_t rsp_item;

	// bench copy of the queue
	logic [TW-1:0]   slot_deadline [QD];
	logic [HW-1:0]   slot_handle   [QD];
	bit              slot_used     [QD];
	int unsigned     slot_age      [QD];

	tequ_pkg::rsp_t       timer_outcomes[$];
	tequ_pkg::rsp_t       oldest_outcome;
	int unsigned          mismatch_count = 0;
	bit                   idle_on;
	bit                   hold_request;
	logic [TW-1:0]        clock_ms;

	timed_event_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the results one accepted request causes and updates the bench queue.
	function automatic void compute_timer_outcomes(input tequ_pkg::req_t item);
		logic [TW-1:0]        due;
		tequ_pkg::rsp_t       outcome;
		tequ_pkg::rsp_t       held;
		bit                   have_held;
		int                   free_slot;
		int                   best;
		int                   fired;
		int unsigned          occupied;
		have_held = 1'b0;
		free_slot = -1;
		occupied  = 0;
		if (item.operation == tequ_pkg::OP_SCHEDULE) begin
			due = item.now_ms + item.delay_ms;
			for (int i = 0; i < QD; i++) begin
				if (slot_used[i])
					occupied++;
				else if (free_slot < 0)
					free_slot = i;
			end
			outcome.fired_handle = item.event_handle;
			outcome.due_time     = due;
			outcome.last_of_run  = 1'b1;
			if (free_slot < 0) begin
				outcome.result_kind = tequ_pkg::KIND_REJECTED;
			end else begin
				outcome.result_kind      = tequ_pkg::KIND_ACCEPTED;
				slot_deadline[free_slot] = due;
				slot_handle[free_slot]   = item.event_handle;
				slot_age[free_slot]      = occupied;
				slot_used[free_slot]     = 1'b1;
			end
			timer_outcomes.insert(timer_outcomes.size(), outcome);
		end else begin
			for (fired = 0; fired < QD; fired++) begin
				best = -1;
				for (int i = 0; i < QD; i++) begin
					if (slot_used[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
					    (slot_deadline[i] == slot_deadline[best] &&
					     slot_age[i] < slot_age[best])))
						best = i;
				end
				if (best < 0 || item.now_ms < slot_deadline[best])
					break;
				if (have_held)
					timer_outcomes.insert(timer_outcomes.size(), held);
				held.result_kind  = tequ_pkg::KIND_FIRED;
				held.fired_handle = slot_handle[best];
				held.due_time     = slot_deadline[best];
				held.last_of_run  = 1'b0;
				have_held         = 1'b1;
				slot_used[best]   = 1'b0;
				// keep ages dense: everything younger moves down one
				for (int i = 0; i < QD; i++)
					if (slot_used[i] && slot_age[i] > slot_age[best])
						slot_age[i]--;
			end
			if (have_held) begin
				held.last_of_run = 1'b1;
				timer_outcomes.insert(timer_outcomes.size(), held);
			end
		end
	endfunction

	// Entered just after a falling edge; returns just after one.
	task automatic send_request(input tequ_pkg::req_t item);
		req_item  <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		compute_timer_outcomes(item);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic schedule_at(input logic [TW-1:0] now_ms,
	                           input logic [TW-1:0] delay_ms,
	                           input logic [HW-1:0] handle);
		tequ_pkg::req_t item;
		item.operation    = tequ_pkg::OP_SCHEDULE;
		item.now_ms       = now_ms;
		item.delay_ms     = delay_ms;
		item.event_handle = handle;
		send_request(item);
	endtask

	task automatic check_at(input logic [TW-1:0] now_ms);
		tequ_pkg::req_t item;
		item.operation    = tequ_pkg::OP_CHECK;
		item.now_ms       = now_ms;
		item.delay_ms     = $urandom;  // ignored by a check
		item.event_handle = HW'($urandom);
		send_request(item);
	endtask

	task automatic drain_outcomes();
		req_valid <= 1'b0;
		while (timer_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_check();
		check_at('1);
	endtask

	// Fill every slot with ties and wrapped deadlines, overflow once, then fire the lot.
	task automatic test_fill_and_reject();
		schedule_at(32'h0000_0000, 32'h0000_0000, 16'h0000);
		schedule_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		schedule_at(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001);
		schedule_at(32'd100, 32'd0, 16'h0002);
		schedule_at(32'd40, 32'd60, 16'h0003);
		schedule_at(32'd0, 32'd100, 16'h0004);
		schedule_at(32'd0, 32'hFFFF_FFFF, 16'h0005);
		for (int i = 0; i < 9; i++)
			schedule_at($urandom_range(0, 5000), $urandom_range(0, 5000), HW'($urandom));
		schedule_at(32'h1234_5678, 32'd1000, 16'hA5A5);
		check_at(32'hFFFF_FFFF);
	endtask

	// Removing a middle-aged entry must keep tie order among the rest.
	task automatic test_age_compaction();
		schedule_at(32'd0, 32'd50, 16'h0101);
		schedule_at(32'd0, 32'd10, 16'h0202);
		schedule_at(32'd0, 32'd50, 16'h0303);
		check_at(32'd5);
		check_at(32'd49);
		schedule_at(32'd20, 32'd30, 16'h0404);
		check_at(32'd50);
	endtask

	task automatic test_random_traffic(input int unsigned count);
		tequ_pkg::req_t item;
		int unsigned    pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				// noise: any field value at all
				item.operation    = tequ_pkg::op_t'($urandom_range(0, 1));
				item.now_ms       = $urandom;
				item.delay_ms     = $urandom;
				item.event_handle = HW'($urandom);
			end else if (pick < 62) begin
				item.operation    = tequ_pkg::OP_SCHEDULE;
				item.now_ms       = clock_ms;
				item.delay_ms     = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
				item.event_handle = HW'($urandom);
			end else begin
				item.operation    = tequ_pkg::OP_CHECK;
				item.delay_ms     = $urandom;
				item.event_handle = HW'($urandom);
				if ($urandom_range(0, 14) == 0) begin
					item.now_ms = '1;  // flush stragglers
				end else begin
					clock_ms    = clock_ms + $urandom_range(0, 60);
					item.now_ms = clock_ms;
				end
			end
			send_request(item);
		end
	endtask

	// Receiver holds off while requests keep coming, so the block backs up.
	task automatic test_output_backpressure();
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++)
			schedule_at(clock_ms, $urandom_range(0, 500), HW'($urandom));
		clock_ms = clock_ms + 600;
		check_at(clock_ms);
	endtask

	task automatic test_drain_pause();
		test_random_traffic(10);
		drain_outcomes();
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_item     = '0;
		idle_on      = 1'b1;
		hold_request = 1'b0;
		clock_ms     = $urandom;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_check();
		test_fill_and_reject();
		test_age_compaction();
		test_random_traffic(140);
		test_output_backpressure();
		idle_on = 1'b0;
		test_random_traffic(50);
		idle_on = 1'b1;
		test_drain_pause();
		test_random_traffic(120);
		idle_on = 1'b0;
		test_random_traffic(40);

		drain_outcomes();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : receiver
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left  = 0;
		rsp_ready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (timer_outcomes.size() == 0) begin
				$error("unexpected transfer: kind %0d handle %h due %h",
				       rsp_item.result_kind, rsp_item.fired_handle, rsp_item.due_time);
				mismatch_count++;
			end else begin
				oldest_outcome = timer_outcomes.pop_front();
				if (rsp_item.result_kind !== oldest_outcome.result_kind) begin
					$error("result_kind: expected %0d, got %0d",
					       oldest_outcome.result_kind, rsp_item.result_kind);
					mismatch_count++;
				end
				if (rsp_item.fired_handle !== oldest_outcome.fired_handle) begin
					$error("fired_handle: expected %h, got %h",
					       oldest_outcome.fired_handle, rsp_item.fired_handle);
					mismatch_count++;
				end
				if (rsp_item.due_time !== oldest_outcome.due_time) begin
					$error("due_time: expected %h, got %h",
					       oldest_outcome.due_time, rsp_item.due_time);
					mismatch_count++;
				end
				if (rsp_item.last_of_run !== oldest_outcome.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d",
					       oldest_outcome.last_of_run, rsp_item.last_of_run);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run if neither side completes a transfer for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
